/* rtl/core/wnst_pkg.sv */
// shared constants, codes and types of the worker node slot table
`default_nettype none

package wnst_pkg;

  localparam int SLOTS   = 16;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int MAX_RES = 16;

  // function codes
  localparam logic [2:0] FN_LOGIN   = 3'd0;
  localparam logic [2:0] FN_LOGOUT  = 3'd1;
  localparam logic [2:0] FN_SELECT  = 3'd2;
  localparam logic [2:0] FN_REPORT  = 3'd3;
  localparam logic [2:0] FN_OUTCOME = 3'd4;

  // slot states
  localparam logic [1:0] SLOT_EMPTY   = 2'd0;
  localparam logic [1:0] SLOT_ONLINE  = 2'd1;
  localparam logic [1:0] SLOT_BUSY    = 2'd2;
  localparam logic [1:0] SLOT_OFFLINE = 2'd3;

  // configuration register index and reset value
  localparam logic       REG_RETRY_LIMIT = 1'b0;
  localparam logic [7:0] RETRY_RESET     = 8'd3;

  // one write access to the slot store: state, retry and address writes share the slot index
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             we_state;
    logic [1:0]       state;
    logic             we_retry;
    logic [7:0]       retry;
    logic             we_addr;
    logic [31:0]      ip;
    logic [15:0]      port;
  } slot_acc_t;

endpackage

`default_nettype wire

/* rtl/core/wnst_store.sv */
// slot store: state and retry flops plus the address/port memory
`default_nettype none

module wnst_store (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire wnst_pkg::slot_acc_t     acc,
  input  wire logic [wnst_pkg::IDX_W-1:0] st_addr,
  input  wire logic [wnst_pkg::IDX_W-1:0] rd_addr,
  output logic [1:0]                   rd_state,
  output logic [7:0]                   rd_retry,
  output logic [31:0]                  rd_ip,
  output logic [15:0]                  rd_port
);

  logic [1:0]  state_r [wnst_pkg::SLOTS];
  logic [7:0]  retry_r [wnst_pkg::SLOTS];
  logic [31:0] ip_mem  [wnst_pkg::SLOTS];
  logic [15:0] port_mem [wnst_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < wnst_pkg::SLOTS; i++) begin
        state_r[i] <= wnst_pkg::SLOT_EMPTY;
        retry_r[i] <= 8'd0;
      end
    end else begin
      if (acc.we_state) begin
        state_r[acc.idx] <= acc.state;
      end
      if (acc.we_retry) begin
        retry_r[acc.idx] <= acc.retry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc.we_addr) begin
      ip_mem[acc.idx]   <= acc.ip;
      port_mem[acc.idx] <= acc.port;
    end
    rd_ip   <= ip_mem[rd_addr];
    rd_port <= port_mem[rd_addr];
  end

  assign rd_state = state_r[st_addr];
  assign rd_retry = retry_r[st_addr];

endmodule

`default_nettype wire

/* rtl/core/worker_node_slot_table.sv */
// worker node slot table top level: sequencer, scan pipeline and config port
// login/logout scan one slot per cycle and stop at the first matching slot or the table end
// select emits one result per chosen slot as the scan walks the table, last one on flush
// heartbeat report and task outcome update one slot; busy falls as the last result appears
// a new item is taken only while busy is low, so items do not overlap
// synchronous reset empties every slot, clears retry counts and sets retry_limit to 3
`default_nettype none

module worker_node_slot_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_func,
  input  wire logic [31:0] in_ip_addr,
  input  wire logic [15:0] in_port,
  input  wire logic [4:0]  in_count,
  input  wire logic [3:0]  in_slot,
  input  wire logic        in_ok,
  output logic             out_valid,
  output logic             out_found,
  output logic [3:0]       out_slot_index,
  output logic [31:0]      out_node_ip,
  output logic [15:0]      out_node_port,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  localparam int IW = wnst_pkg::IDX_W;
  localparam int CW = wnst_pkg::CNT_W;

  logic [1:0]    st_r, st_nxt;
  logic [2:0]    func_r, func_nxt;
  logic [31:0]   ip_r, ip_nxt;
  logic [15:0]   port_r, port_nxt;
  logic          ok_r, ok_nxt;
  logic          bad_r, bad_nxt;
  logic [4:0]    want_r, want_nxt;
  logic [4:0]    sel_n_r, sel_n_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          vld_d_r, vld_d_nxt;
  logic [IW-1:0] idx_d_r, idx_d_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [IW-1:0] pend_idx_r, pend_idx_nxt;
  logic [31:0]   pend_ip_r, pend_ip_nxt;
  logic [15:0]   pend_port_r, pend_port_nxt;
  logic [7:0]    limit_r;

  logic          ov_r, ov_nxt;
  logic          of_r, of_nxt;
  logic [3:0]    oi_r, oi_nxt;
  logic [31:0]   oip_r, oip_nxt;
  logic [15:0]   opt_r, opt_nxt;
  logic          ol_r, ol_nxt;

  wnst_pkg::slot_acc_t acc;
  logic [IW-1:0] rd_addr;
  logic [1:0]    rd_state;
  logic [7:0]    rd_retry;
  logic [31:0]   rd_ip;
  logic [15:0]   rd_port;

  logic          scan_end;
  logic [7:0]    retry_inc;
  logic          cfg_wr;

  wnst_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .st_addr  (idx_d_r),
    .rd_addr  (rd_addr),
    .rd_state (rd_state),
    .rd_retry (rd_retry),
    .rd_ip    (rd_ip),
    .rd_port  (rd_port)
  );

  assign busy     = (st_r != ST_IDLE);
  assign scan_end = vld_d_r && (idx_d_r == IW'(wnst_pkg::SLOTS - 1));
  assign retry_inc = (rd_retry == 8'hff) ? 8'hff : rd_retry + 8'd1;

  always_comb begin
    st_nxt        = st_r;
    func_nxt      = func_r;
    ip_nxt        = ip_r;
    port_nxt      = port_r;
    ok_nxt        = ok_r;
    bad_nxt       = bad_r;
    want_nxt      = want_r;
    sel_n_nxt     = sel_n_r;
    idx_nxt       = idx_r;
    vld_d_nxt     = 1'b0;
    idx_d_nxt     = idx_d_r;
    pend_v_nxt    = pend_v_r;
    pend_idx_nxt  = pend_idx_r;
    pend_ip_nxt   = pend_ip_r;
    pend_port_nxt = pend_port_r;
    rd_addr       = idx_r[IW-1:0];

    ov_nxt  = 1'b0;
    of_nxt  = 1'b0;
    oi_nxt  = 4'd0;
    oip_nxt = 32'd0;
    opt_nxt = 16'd0;
    ol_nxt  = 1'b1;

    acc          = '0;
    acc.idx      = idx_d_r;
    acc.ip       = ip_r;
    acc.port     = port_r;

    case (st_r)
      ST_IDLE: begin
        if (start) begin
          func_nxt   = in_func;
          ip_nxt     = in_ip_addr;
          port_nxt   = in_port;
          ok_nxt     = in_ok;
          bad_nxt    = (32'(in_slot) >= 32'(wnst_pkg::SLOTS));
          sel_n_nxt  = 5'd0;
          idx_nxt    = '0;
          pend_v_nxt = 1'b0;
          if (in_count == 5'd0) begin
            want_nxt = 5'd1;
          end else if (in_count > 5'(wnst_pkg::MAX_RES)) begin
            want_nxt = 5'(wnst_pkg::MAX_RES);
          end else begin
            want_nxt = in_count;
          end
          case (in_func)
            wnst_pkg::FN_LOGIN, wnst_pkg::FN_LOGOUT, wnst_pkg::FN_SELECT: begin
              st_nxt = ST_SCAN;
            end
            wnst_pkg::FN_REPORT, wnst_pkg::FN_OUTCOME: begin
              st_nxt    = ST_EXEC;
              idx_d_nxt = IW'(in_slot);
            end
            default: begin
              st_nxt = ST_FLUSH;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // issue stage: one memory read per cycle
        if (idx_r < CW'(wnst_pkg::SLOTS)) begin
          idx_nxt   = idx_r + CW'(1);
          vld_d_nxt = 1'b1;
          idx_d_nxt = idx_r[IW-1:0];
        end
        // evaluate stage: read data of slot idx_d_r
        if (vld_d_r) begin
          case (func_r)
            wnst_pkg::FN_LOGIN: begin
              if (rd_state == wnst_pkg::SLOT_EMPTY) begin
                acc.we_state = 1'b1;
                acc.state    = wnst_pkg::SLOT_ONLINE;
                acc.we_retry = 1'b1;
                acc.retry    = 8'd0;
                acc.we_addr  = 1'b1;
                ov_nxt = 1'b1;
                of_nxt = 1'b1;
                oi_nxt = 4'(idx_d_r);
                st_nxt = ST_IDLE;
              end else if (scan_end) begin
                st_nxt = ST_FLUSH;
              end
            end
            wnst_pkg::FN_LOGOUT: begin
              if (rd_state != wnst_pkg::SLOT_EMPTY && rd_ip == ip_r &&
                  rd_port == port_r) begin
                acc.we_state = 1'b1;
                acc.state    = wnst_pkg::SLOT_EMPTY;
                ov_nxt = 1'b1;
                of_nxt = 1'b1;
                oi_nxt = 4'(idx_d_r);
                st_nxt = ST_IDLE;
              end else if (scan_end) begin
                st_nxt = ST_FLUSH;
              end
            end
            default: begin
              // select: hold one pick back so the final one can carry last
              if (rd_state == wnst_pkg::SLOT_ONLINE) begin
                acc.we_state  = 1'b1;
                acc.state     = wnst_pkg::SLOT_BUSY;
                pend_v_nxt    = 1'b1;
                pend_idx_nxt  = idx_d_r;
                pend_ip_nxt   = rd_ip;
                pend_port_nxt = rd_port;
                sel_n_nxt     = sel_n_r + 5'd1;
                if (pend_v_r) begin
                  ov_nxt  = 1'b1;
                  of_nxt  = 1'b1;
                  oi_nxt  = 4'(pend_idx_r);
                  oip_nxt = pend_ip_r;
                  opt_nxt = pend_port_r;
                  ol_nxt  = 1'b0;
                end
                if (sel_n_nxt == want_r) begin
                  st_nxt = ST_FLUSH;
                end
              end
              if (scan_end) begin
                st_nxt = ST_FLUSH;
              end
            end
          endcase
        end
      end

      ST_EXEC: begin
        ov_nxt = 1'b1;
        st_nxt = ST_IDLE;
        if (!bad_r && rd_state != wnst_pkg::SLOT_EMPTY) begin
          of_nxt = 1'b1;
          oi_nxt = 4'(idx_d_r);
          acc.we_state = 1'b1;
          if (func_r == wnst_pkg::FN_REPORT) begin
            acc.we_retry = 1'b1;
            if (ok_r) begin
              acc.retry = 8'd0;
              acc.state = (rd_state == wnst_pkg::SLOT_BUSY) ?
                          wnst_pkg::SLOT_BUSY : wnst_pkg::SLOT_ONLINE;
            end else begin
              acc.retry = retry_inc;
              acc.state = (retry_inc > limit_r) ?
                          wnst_pkg::SLOT_EMPTY : wnst_pkg::SLOT_OFFLINE;
            end
          end else begin
            acc.state = ok_r ? wnst_pkg::SLOT_ONLINE : wnst_pkg::SLOT_OFFLINE;
          end
        end
      end

      ST_FLUSH: begin
        ov_nxt = 1'b1;
        st_nxt = ST_IDLE;
        if (pend_v_r) begin
          of_nxt  = 1'b1;
          oi_nxt  = 4'(pend_idx_r);
          oip_nxt = pend_ip_r;
          opt_nxt = pend_port_r;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      vld_d_r  <= 1'b0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
      sel_n_r  <= 5'd0;
      want_r   <= 5'd1;
    end else begin
      st_r     <= st_nxt;
      vld_d_r  <= vld_d_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
      sel_n_r  <= sel_n_nxt;
      want_r   <= want_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    ip_r        <= ip_nxt;
    port_r      <= port_nxt;
    ok_r        <= ok_nxt;
    bad_r       <= bad_nxt;
    idx_r       <= idx_nxt;
    idx_d_r     <= idx_d_nxt;
    pend_idx_r  <= pend_idx_nxt;
    pend_ip_r   <= pend_ip_nxt;
    pend_port_r <= pend_port_nxt;
    of_r        <= of_nxt;
    oi_r        <= oi_nxt;
    oip_r       <= oip_nxt;
    opt_r       <= opt_nxt;
    ol_r        <= ol_nxt;
  end

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == wnst_pkg::REG_RETRY_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= wnst_pkg::RETRY_RESET;
    end else if (cfg_wr) begin
      limit_r <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == wnst_pkg::REG_RETRY_LIMIT) ? {24'd0, limit_r} : 32'd0;

  assign out_valid      = ov_r;
  assign out_found      = of_r;
  assign out_slot_index = oi_r;
  assign out_node_ip    = oip_r;
  assign out_node_port  = opt_r;
  assign out_last       = ol_r;

`ifndef ASSERT_OFF
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(st_r != ST_IDLE))
    else $error("result transfer without an item in progress");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (st_r == ST_IDLE))
    else $error("last result while the sequencer is still running");

  a_sel_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN) |-> (sel_n_r <= want_r))
    else $error("select picked more slots than requested");
`endif

endmodule

`default_nettype wire

/* bench/testbench.sv */
// testbench of the worker node slot table: command driver, slot scoreboard and apb register checks
module testbench;

  localparam logic [2:0] FN_SPARE_LO = 3'd5;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;
  localparam logic [2:0] ADDR_RETRY_LIMIT = {wnst_pkg::REG_RETRY_LIMIT, 2'b00};
  localparam int RAND_PER_PHASE = 27;
  localparam int SAT_SWEEP = 258;
  localparam int TIMEOUT = 4_000_000;

  typedef struct {
    logic [2:0]  func;
    logic [31:0] ip;
    logic [15:0] port;
    logic [4:0]  count;
    logic [3:0]  slot;
    logic        ok;
  } cmd_t;

  typedef struct {
    logic        found;
    logic [3:0]  idx;
    logic [31:0] ip;
    logic [15:0] port;
    logic        last;
  } res_t;

  class slot_scoreboard;
    bit [1:0]  state [wnst_pkg::SLOTS];
    bit [31:0] ip_tab [wnst_pkg::SLOTS];
    bit [15:0] port_tab [wnst_pkg::SLOTS];
    bit [7:0]  retries [wnst_pkg::SLOTS];
    bit [7:0]  retry_limit;
    res_t      pending [$];
    int        fails;
    int        checked;

    function new();
      foreach (state[i]) begin
        state[i] = wnst_pkg::SLOT_EMPTY;
        ip_tab[i] = '0;
        port_tab[i] = '0;
        retries[i] = '0;
      end
      retry_limit = wnst_pkg::RETRY_RESET;
      fails = 0;
      checked = 0;
    endfunction

    function void push(bit found, bit [3:0] idx, bit [31:0] ip, bit [15:0] port, bit last);
      res_t r;
      r.found = found;
      r.idx = idx;
      r.ip = ip;
      r.port = port;
      r.last = last;
      pending.push_back(r);
    endfunction

    // update the slot table for one accepted command and queue its results
    function void note_input(cmd_t c);
      int i;
      int k;
      int want;
      int picks [$];
      bit done;
      done = 0;
      case (c.func)
        wnst_pkg::FN_LOGIN: begin
          for (i = 0; i < wnst_pkg::SLOTS && !done; i++) begin
            if (state[i] == wnst_pkg::SLOT_EMPTY) begin
              state[i] = wnst_pkg::SLOT_ONLINE;
              ip_tab[i] = c.ip;
              port_tab[i] = c.port;
              retries[i] = '0;
              push(1, 4'(i), 0, 0, 1);
              done = 1;
            end
          end
          if (!done) push(0, 0, 0, 0, 1);
        end
        wnst_pkg::FN_LOGOUT: begin
          for (i = 0; i < wnst_pkg::SLOTS && !done; i++) begin
            if (state[i] != wnst_pkg::SLOT_EMPTY && ip_tab[i] == c.ip &&
                port_tab[i] == c.port) begin
              state[i] = wnst_pkg::SLOT_EMPTY;
              push(1, 4'(i), 0, 0, 1);
              done = 1;
            end
          end
          if (!done) push(0, 0, 0, 0, 1);
        end
        wnst_pkg::FN_SELECT: begin
          // a zero count still takes one slot, anything above the result limit is clipped
          want = (c.count == 0) ? 1 :
                 (c.count > wnst_pkg::MAX_RES) ? wnst_pkg::MAX_RES : int'(c.count);
          for (i = 0; i < wnst_pkg::SLOTS && picks.size() < want; i++) begin
            if (state[i] == wnst_pkg::SLOT_ONLINE) begin
              state[i] = wnst_pkg::SLOT_BUSY;
              picks.push_back(i);
            end
          end
          if (picks.size() == 0) push(0, 0, 0, 0, 1);
          for (k = 0; k < picks.size(); k++) begin
            push(1, 4'(picks[k]), ip_tab[picks[k]], port_tab[picks[k]],
                 k == picks.size() - 1);
          end
        end
        wnst_pkg::FN_REPORT, wnst_pkg::FN_OUTCOME: begin
          i = int'(c.slot);
          if (state[i] == wnst_pkg::SLOT_EMPTY) begin
            push(0, 0, 0, 0, 1);
          end else begin
            if (c.func == wnst_pkg::FN_OUTCOME) begin
              state[i] = c.ok ? wnst_pkg::SLOT_ONLINE : wnst_pkg::SLOT_OFFLINE;
            end else if (c.ok) begin
              if (state[i] != wnst_pkg::SLOT_BUSY) state[i] = wnst_pkg::SLOT_ONLINE;
              retries[i] = '0;
            end else begin
              if (retries[i] != 8'hFF) retries[i]++;
              state[i] = (retries[i] > retry_limit) ? wnst_pkg::SLOT_EMPTY :
                                                      wnst_pkg::SLOT_OFFLINE;
            end
            push(1, 4'(i), 0, 0, 1);
          end
        end
        default: push(0, 0, 0, 0, 1);
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      fails++;
    endtask

    task check_result(res_t got);
      res_t exp;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing pending (slot %0d)", got.idx));
      end else begin
        exp = pending.pop_front();
        checked++;
        if (got.found !== exp.found)
          report($sformatf("found %b, want %b", got.found, exp.found));
        if (got.idx !== exp.idx)
          report($sformatf("slot_index %0d, want %0d", got.idx, exp.idx));
        if (got.ip !== exp.ip)
          report($sformatf("node_ip %h, want %h", got.ip, exp.ip));
        if (got.port !== exp.port)
          report($sformatf("node_port %h, want %h", got.port, exp.port));
        if (got.last !== exp.last)
          report($sformatf("last %b, want %b", got.last, exp.last));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_func;
  logic [31:0] in_ip_addr;
  logic [15:0] in_port;
  logic [4:0]  in_count;
  logic [3:0]  in_slot;
  logic        in_ok;
  logic        out_valid;
  logic        out_found;
  logic [3:0]  out_slot_index;
  logic [31:0] out_node_ip;
  logic [15:0] out_node_port;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  slot_scoreboard sb = new();
  int  n_cmds;
  bit  quiet;
  int  mid_limit;

  worker_node_slot_table dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_ip_addr(in_ip_addr), .in_port(in_port),
    .in_count(in_count), .in_slot(in_slot), .in_ok(in_ok),
    .out_valid(out_valid), .out_found(out_found), .out_slot_index(out_slot_index),
    .out_node_ip(out_node_ip), .out_node_port(out_node_port), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT);
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin : watch_results
    res_t got;
    if (rst_n && out_valid) begin
      got.found = out_found;
      got.idx = out_slot_index;
      got.ip = out_node_ip;
      got.port = out_node_port;
      got.last = out_last;
      sb.check_result(got);
    end
  end

  function automatic cmd_t mk(logic [2:0] f, logic [31:0] ip, logic [15:0] port,
                              logic [4:0] cnt, logic [3:0] s, logic ok);
    cmd_t c;
    c.func = f;
    c.ip = ip;
    c.port = port;
    c.count = cnt;
    c.slot = s;
    c.ok = ok;
    return c;
  endfunction

  function automatic int gap_draw();
    if (quiet) return 0;
    return $urandom_range(0, 4);
  endfunction

  // mostly well-formed traffic: logouts and reports aim at occupied slots
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int live [$];
    int pick;
    int j;
    c = mk(wnst_pkg::FN_LOGIN, $urandom, 16'($urandom), 5'($urandom), 4'($urandom),
           1'($urandom));
    for (j = 0; j < wnst_pkg::SLOTS; j++)
      if (sb.state[j] != wnst_pkg::SLOT_EMPTY) live.push_back(j);
    pick = $urandom_range(0, 99);
    if (live.size() > 0) j = live[$urandom_range(0, live.size() - 1)];
    if (pick < 25) begin
      c.func = wnst_pkg::FN_LOGIN;
      if (live.size() > 0 && $urandom_range(0, 5) == 0) begin
        c.ip = sb.ip_tab[j];
        c.port = sb.port_tab[j];
      end
    end else if (pick < 43) begin
      c.func = wnst_pkg::FN_LOGOUT;
      if (live.size() > 0 && $urandom_range(0, 4) != 0) begin
        c.ip = sb.ip_tab[j];
        c.port = sb.port_tab[j];
      end
    end else if (pick < 61) begin
      c.func = wnst_pkg::FN_SELECT;
      if ($urandom_range(0, 3) != 0) c.count = 5'($urandom_range(0, 4));
    end else if (pick < 95) begin
      c.func = (pick < 81) ? wnst_pkg::FN_REPORT : wnst_pkg::FN_OUTCOME;
      if (live.size() > 0 && $urandom_range(0, 7) != 0) c.slot = 4'(j);
    end else begin
      c.func = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
    end
    return c;
  endfunction

  task automatic send(input cmd_t c, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_func <= c.func;
    in_ip_addr <= c.ip;
    in_port <= c.port;
    in_count <= c.count;
    in_slot <= c.slot;
    in_ok <= c.ok;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_input(c);
    n_cmds++;
  endtask

  // stop issuing, let every pending result arrive, then allow the worst-case scan time
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0 || busy !== 1'b0) @(negedge clk);
    repeat (wnst_pkg::SLOTS + 4) @(negedge clk);
  endtask

  task automatic cfg_access(input bit wr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_RETRY_LIMIT;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (wr) sb.retry_limit = data[7:0];
    else if (prdata !== {24'h0, sb.retry_limit})
      sb.report($sformatf("retry_limit read %h, want %h", prdata, sb.retry_limit));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_random(input int n);
    repeat (n) begin
      if ($urandom_range(0, 14) == 0) quiet = !quiet;
      send(rand_cmd(), gap_draw());
    end
  endtask

  task automatic new_limit(input logic [7:0] lim);
    drain();
    cfg_access(1'b1, {24'h0, lim});
    cfg_access(1'b0, '0);
  endtask

  initial begin : main
    int i;
    int target;
    n_cmds = 0;
    quiet = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = wnst_pkg::FN_LOGIN;
    in_ip_addr = '0;
    in_port = '0;
    in_count = '0;
    in_slot = '0;
    in_ok = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    cfg_access(1'b0, '0);

    // directed: empty table, ignored codes, fill to full, select corners, slot updates
    send(mk(wnst_pkg::FN_SELECT, 0, 0, 5'd1, 0, 1), gap_draw());
    send(mk(wnst_pkg::FN_REPORT, 0, 0, 0, 4'd4, 1), gap_draw());
    send(mk(FN_SPARE_HI, '1, '1, '1, '1, 1), gap_draw());
    for (i = 0; i < wnst_pkg::SLOTS; i++) begin
      if (i == 0) send(mk(wnst_pkg::FN_LOGIN, 32'h0, 16'h0, 0, 0, 0), gap_draw());
      else if (i == 1) send(mk(wnst_pkg::FN_LOGIN, '1, '1, 0, 0, 0), gap_draw());
      else send(mk(wnst_pkg::FN_LOGIN, $urandom, 16'($urandom), 0, 0, 0), gap_draw());
    end
    send(mk(wnst_pkg::FN_LOGIN, 32'h0a000001, 16'd8080, 0, 0, 0), gap_draw());
    send(mk(wnst_pkg::FN_SELECT, 0, 0, 5'd0, 0, 0), gap_draw());
    send(mk(wnst_pkg::FN_SELECT, 0, 0, 5'd31, 0, 0), gap_draw());
    send(mk(wnst_pkg::FN_REPORT, 0, 0, 0, 4'd0, 1), gap_draw());
    send(mk(wnst_pkg::FN_REPORT, 0, 0, 0, 4'd2, 0), gap_draw());
    send(mk(wnst_pkg::FN_OUTCOME, 0, 0, 0, 4'd2, 1), gap_draw());
    send(mk(wnst_pkg::FN_LOGOUT, '1, '1, 0, 0, 0), gap_draw());
    send(mk(wnst_pkg::FN_OUTCOME, 0, 0, 0, 4'd1, 0), gap_draw());
    send(mk(wnst_pkg::FN_LOGOUT, 32'h0, 16'h1, 0, 0, 0), gap_draw());
    send(mk(wnst_pkg::FN_OUTCOME, 0, 0, 0, 4'd15, 0), gap_draw());

    run_random(RAND_PER_PHASE);
    new_limit(8'd0);
    run_random(RAND_PER_PHASE);

    // at the top limit the retry count saturates and the slot is never freed
    new_limit(8'd255);
    send(mk(wnst_pkg::FN_LOGIN, $urandom, 16'($urandom), 0, 0, 0), gap_draw());
    target = -1;
    for (i = wnst_pkg::SLOTS - 1; i >= 0; i--)
      if (sb.state[i] != wnst_pkg::SLOT_EMPTY) target = i;
    repeat (SAT_SWEEP)
      send(mk(wnst_pkg::FN_REPORT, $urandom, 16'($urandom), 5'($urandom), 4'(target), 0),
           gap_draw());
    send(mk(wnst_pkg::FN_REPORT, 0, 0, 0, 4'(target), 1), gap_draw());
    run_random(RAND_PER_PHASE / 2);

    new_limit(8'd1);
    run_random(RAND_PER_PHASE);
    mid_limit = $urandom_range(2, 254);
    new_limit(mid_limit[7:0]);
    run_random(RAND_PER_PHASE);

    drain();
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    $display("run: %0d commands, %0d results checked, %0d mismatches", n_cmds, sb.checked,
             sb.fails);
    $display("retry limits 3, 0, 255 (saturating sweep), 1 and %0d", mid_limit);
    if (sb.fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* worker_node_slot_table.f */
rtl/core/wnst_pkg.sv
rtl/core/wnst_store.sv
rtl/core/worker_node_slot_table.sv
bench/testbench.sv
